// ----- src/ffa_pkg.sv -----
// Shared constants, types and codes for the first-fit heap allocator.
package ffa_pkg;

    localparam int unsigned HEAP_MAX_BYTES = 65536;
    localparam int unsigned HEADER_BYTES   = 24;
    localparam int unsigned NUM_CELLS      = 64;
    localparam int unsigned IDX_W          = 7;
    localparam int unsigned SEL_W          = 6;
    localparam int unsigned ADDR_W         = 16;
    localparam int unsigned SIZE_W         = 17;
    localparam int unsigned SUM_W          = 18;
    localparam int unsigned STORE_DEPTH    = HEAP_MAX_BYTES / 8;
    localparam int unsigned STORE_AW       = 13;

    localparam logic [SIZE_W-1:0] HDR_SZ    = SIZE_W'(HEADER_BYTES);
    localparam logic [SUM_W-1:0]  HDR_SUM   = SUM_W'(HEADER_BYTES);
    localparam logic [SIZE_W-1:0] HEAP_MIN  = SIZE_W'(64);
    localparam logic [SIZE_W-1:0] HEAP_LIM  = SIZE_W'(HEAP_MAX_BYTES);

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_OOM  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
    } ext_t;

    typedef struct packed {
        logic              init;
        logic              shl;
        logic              shr;
        logic [IDX_W-1:0]  sh_idx;
        logic              wr;
        logic [IDX_W-1:0]  wr_idx;
        logic [ADDR_W-1:0] wr_start;
        logic [SIZE_W-1:0] wr_size;
    } cell_cmd_t;

    typedef struct packed {
        logic [SIZE_W-1:0] rsize;
        logic [SIZE_W-1:0] heap;
        logic [ADDR_W-1:0] h;
        logic [SUM_W-1:0]  endv;
    } cell_key_t;

    typedef struct packed {
        logic fit;
        logic lt;
        logic la;
        logic ra;
        logic ovl;
    } cell_flag_t;

endpackage

// ----- src/first_fit_heap_allocator_top.sv -----
// Top level of the first-fit heap allocator: control, block size store and the extent cell row.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_ready, mode, request_bytes,       | in
//          | block_offset                                   |
//  out     | out_valid, out_ready, payload_offset, status   | out
//  cfg     | cfg_we, cfg_wdata (heap_bytes)                 | in
//
//  Each item passes through accept, evaluation in all cells, planning and
//  applying the cell update, and hand-over to the output register. A free that is
//  null, misaligned or below the first header skips evaluation and planning.
//  The cell row evaluates all 64 extents at once, so the time taken does not
//  depend on how many extents are held; a stalled output adds its wait.
//  After reset the init state loads the heap as a single free extent.
//  A config write rebuilds the row; the rebuilt row is held from the cycle after the write.
module first_fit_heap_allocator_top
    import ffa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              mode,
    input  logic [15:0]       request_bytes,
    input  logic [15:0]       block_offset,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [15:0]       payload_offset,
    output logic [1:0]        status,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata
);

    typedef enum logic [5:0] {
        S_INIT = 6'b000001,
        S_IDLE = 6'b000010,
        S_EVAL = 6'b000100,
        S_PLAN = 6'b001000,
        S_RESP = 6'b010000,
        S_SKIP = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [SIZE_W-1:0] heap_reg;
    logic              mode_reg;
    logic [SIZE_W-1:0] rsize_reg;
    logic [ADDR_W-1:0] off_reg;
    logic [SIZE_W-1:0] rd_reg;
    logic              bad_reg;
    logic [NUM_CELLS-1:0] fit_reg, lt_reg, la_reg, ra_reg, ovl_reg;
    logic [ADDR_W-1:0] res_off_reg;
    logic [1:0]        res_st_reg;
    logic              out_valid_reg;
    logic [ADDR_W-1:0] payload_offset_reg;
    logic [1:0]        status_reg;

    logic [SIZE_W-1:0] store_mem [STORE_DEPTH];

    ext_t       cells   [NUM_CELLS];
    cell_flag_t flags   [NUM_CELLS];
    cell_cmd_t  cmd;
    cell_key_t  key;

    logic accept;
    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    // Clamp the written heap size to a multiple of 8 within the legal range.
    logic [SIZE_W-1:0] cfg_heap;
    always_comb
    begin
        cfg_heap = {cfg_wdata[SIZE_W-1:3], 3'b000};
        if (cfg_heap < HEAP_MIN)
        begin
            cfg_heap = HEAP_MIN;
        end
        if (cfg_heap > HEAP_LIM)
        begin
            cfg_heap = HEAP_LIM;
        end
    end

    // Key seen by every cell; header of the freed block is offset minus header.
    assign key.rsize = rsize_reg;
    assign key.heap  = heap_reg;
    assign key.h     = off_reg - ADDR_W'(HEADER_BYTES);
    assign key.endv  = SUM_W'(off_reg) + SUM_W'(rd_reg);

    // Cell row: each cell sees its neighbours, the ends see an empty extent.
    genvar g;
    generate
        for (g = 0; g < NUM_CELLS; g++)
        begin : g_cell
            ext_t lft, rgt;
            if (g == 0)
            begin : g_first
                assign lft = '0;
            end
            else
            begin : g_mid_l
                assign lft = cells[g-1];
            end
            if (g == NUM_CELLS - 1)
            begin : g_last
                assign rgt = '0;
            end
            else
            begin : g_mid_r
                assign rgt = cells[g+1];
            end
            ffa_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .pos   (IDX_W'(g)),
                .cmd   (cmd),
                .key   (key),
                .left  (lft),
                .right (rgt),
                .cur   (cells[g]),
                .flag  (flags[g])
            );
        end
    endgenerate

    // First fitting extent.
    logic [SEL_W-1:0] fit_idx;
    always_comb
    begin
        fit_idx = '0;
        for (int i = NUM_CELLS - 1; i >= 0; i--)
        begin
            if (fit_reg[i])
            begin
                fit_idx = SEL_W'(i);
            end
        end
    end

    // Insert position: number of held extents that start below the block.
    logic [IDX_W-1:0] ins_p;
    logic [SEL_W-1:0] p_sel, pm_sel;
    assign ins_p  = IDX_W'($countones(lt_reg));
    assign p_sel  = ins_p[SEL_W-1:0];
    assign pm_sel = p_sel - SEL_W'(1);

    ext_t fit_ext, left_ext, right_ext;
    assign fit_ext   = cells[fit_idx];
    assign left_ext  = cells[pm_sel];
    assign right_ext = cells[p_sel];

    logic              split;
    logic [ADDR_W-1:0] alloc_pay;
    logic [SIZE_W-1:0] alloc_sz;
    logic              any_la, any_ra, free_ok;
    assign split     = SUM_W'(fit_ext.size) >= (SUM_W'(rsize_reg) + HDR_SUM + SUM_W'(8));
    assign alloc_pay = fit_ext.start + ADDR_W'(HEADER_BYTES);
    assign alloc_sz  = split ? rsize_reg : fit_ext.size;
    assign any_la    = |la_reg;
    assign any_ra    = |ra_reg;
    assign free_ok   = !bad_reg && !(|ovl_reg);

    // Cell command: rebuild, remove, overwrite, merge or insert.
    always_comb
    begin
        cmd = '0;
        if (cfg_we)
        begin
            cmd.init    = 1'b1;
            cmd.wr_size = cfg_heap - HDR_SZ;
        end
        else if (state_reg == S_INIT)
        begin
            cmd.init    = 1'b1;
            cmd.wr_size = heap_reg - HDR_SZ;
        end
        else if (state_reg == S_PLAN && !mode_reg && (|fit_reg))
        begin
            if (split)
            begin
                // Tail stays where the extent was: neighbours never touch it.
                cmd.wr       = 1'b1;
                cmd.wr_idx   = IDX_W'(fit_idx);
                cmd.wr_start = alloc_pay + ADDR_W'(rsize_reg);
                cmd.wr_size  = fit_ext.size - rsize_reg - HDR_SZ;
            end
            else
            begin
                cmd.shl    = 1'b1;
                cmd.sh_idx = IDX_W'(fit_idx);
            end
        end
        else if (state_reg == S_PLAN && mode_reg && free_ok)
        begin
            if (any_la && any_ra)
            begin
                cmd.shl     = 1'b1;
                cmd.sh_idx  = ins_p;
                cmd.wr      = 1'b1;
                cmd.wr_idx  = ins_p - IDX_W'(1);
                cmd.wr_start = left_ext.start;
                cmd.wr_size = left_ext.size + HDR_SZ + rd_reg + HDR_SZ + right_ext.size;
            end
            else if (any_la)
            begin
                cmd.wr       = 1'b1;
                cmd.wr_idx   = ins_p - IDX_W'(1);
                cmd.wr_start = left_ext.start;
                cmd.wr_size  = left_ext.size + HDR_SZ + rd_reg;
            end
            else if (any_ra)
            begin
                cmd.wr       = 1'b1;
                cmd.wr_idx   = ins_p;
                cmd.wr_start = key.h;
                cmd.wr_size  = right_ext.size + HDR_SZ + rd_reg;
            end
            else if (!cells[NUM_CELLS-1].valid)
            begin
                cmd.shr      = 1'b1;
                cmd.sh_idx   = ins_p;
                cmd.wr       = 1'b1;
                cmd.wr_idx   = ins_p;
                cmd.wr_start = key.h;
                cmd.wr_size  = rd_reg;
            end
        end
    end

    // Early reject for a free: null, misaligned or below the first header.
    logic early_skip;
    assign early_skip = mode && ((block_offset < ADDR_W'(HEADER_BYTES))
                        || (block_offset[2:0] != 3'(HEADER_BYTES % 8)));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT: state_next = S_IDLE;
            S_IDLE: if (accept) state_next = early_skip ? S_SKIP : S_EVAL;
            S_EVAL: state_next = S_PLAN;
            S_PLAN: state_next = S_RESP;
            S_SKIP: state_next = S_RESP;
            S_RESP: if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            heap_reg      <= HEAP_LIM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                heap_reg <= cfg_heap;
            end
            if (state_reg == S_RESP && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: hold the item, flags and result.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= mode;
            rsize_reg <= (SIZE_W'(request_bytes) + SIZE_W'(7)) & ~SIZE_W'(7);
            off_reg   <= block_offset;
        end
        if (state_reg == S_EVAL)
        begin
            bad_reg <= key.endv > SUM_W'(heap_reg);
            for (int i = 0; i < NUM_CELLS; i++)
            begin
                fit_reg[i] <= flags[i].fit;
                lt_reg[i]  <= flags[i].lt;
                la_reg[i]  <= flags[i].la;
                ra_reg[i]  <= flags[i].ra;
                ovl_reg[i] <= flags[i].ovl;
            end
        end
        if (state_reg == S_SKIP)
        begin
            res_off_reg <= '0;
            res_st_reg  <= ST_DONE;
        end
        if (state_reg == S_PLAN)
        begin
            res_off_reg <= '0;
            res_st_reg  <= ST_DONE;
            if (!mode_reg)
            begin
                if (|fit_reg)
                begin
                    res_off_reg <= alloc_pay;
                end
                else
                begin
                    res_st_reg <= ST_OOM;
                end
            end
            else if (free_ok && !any_la && !any_ra && cells[NUM_CELLS-1].valid)
            begin
                res_st_reg <= ST_FULL;
            end
        end
        if (state_reg == S_RESP && (!out_valid_reg || out_ready))
        begin
            payload_offset_reg <= res_off_reg;
            status_reg         <= res_st_reg;
        end
    end

    // Block size store: read in the idle state at the offered offset, written on allocate.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            rd_reg <= store_mem[block_offset[ADDR_W-1:3]];
        end
        if (state_reg == S_PLAN && !mode_reg && (|fit_reg))
        begin
            store_mem[alloc_pay[ADDR_W-1:3]] <= alloc_sz;
        end
    end

    assign out_valid      = out_valid_reg;
    assign payload_offset = payload_offset_reg;
    assign status         = status_reg;

    logic [NUM_CELLS-1:0] valid_vec;
    always_comb
    begin
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            valid_vec[i] = cells[i].valid;
        end
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + NUM_CELLS'(1))) == '0)
        else $error("extent cells not packed from the left");

    a_cfg_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (valid_vec == NUM_CELLS'(1)) && (cells[0].start == '0))
        else $error("config write did not rebuild a single extent");

endmodule

// ----- src/ffa_cell.sv -----
// One free-extent cell: holds an extent, compares it against the key, shifts with neighbours.
module ffa_cell
    import ffa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] pos,
    input  cell_cmd_t        cmd,
    input  cell_key_t        key,
    input  ext_t             left,
    input  ext_t             right,
    output ext_t             cur,
    output cell_flag_t       flag
);

    ext_t ext_reg;
    ext_t ext_next;
    logic [SUM_W-1:0] ext_end;
    logic [SUM_W-1:0] start_w;

    assign cur     = ext_reg;
    assign start_w = SUM_W'(ext_reg.start);
    assign ext_end = start_w + HDR_SUM + SUM_W'(ext_reg.size);

    always_comb
    begin
        flag.fit = ext_reg.valid && (ext_reg.size >= key.rsize)
                   && ((SIZE_W'(ext_reg.start) + HDR_SZ) < key.heap);
        flag.lt  = ext_reg.valid && (ext_reg.start < key.h);
        flag.la  = ext_reg.valid && (ext_end == SUM_W'(key.h));
        flag.ra  = ext_reg.valid && (start_w == key.endv);
        flag.ovl = ext_reg.valid && (SUM_W'(key.h) < ext_end) && (start_w < key.endv);
    end

    always_comb
    begin
        ext_next = ext_reg;
        if (cmd.init)
        begin
            ext_next.valid = (pos == '0);
            ext_next.start = '0;
            ext_next.size  = (pos == '0) ? cmd.wr_size : '0;
        end
        else if (cmd.shl && pos >= cmd.sh_idx)
        begin
            ext_next = right;
        end
        else if (cmd.shr && pos > cmd.sh_idx)
        begin
            ext_next = left;
        end
        else if (cmd.wr && pos == cmd.wr_idx)
        begin
            ext_next.valid = 1'b1;
            ext_next.start = cmd.wr_start;
            ext_next.size  = cmd.wr_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg <= '0;
        end
        else
        begin
            ext_reg <= ext_next;
        end
    end

endmodule

// ----- tb/sv/first_fit_heap_allocator_top_tb.sv -----
// Testbench for the first-fit heap allocator: directed and random items checked against a predictor.
module first_fit_heap_allocator_top_tb;
    import ffa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IDLE_LIMIT = 5000;  // cycles with no item moving on either channel
    localparam int unsigned DRAIN_WAIT = 12;    // settle time after the last result
    localparam logic        OP_ALLOC   = 1'b0;
    localparam logic        OP_FREE    = 1'b1;

    typedef struct {
        logic [15:0] offset;
        logic [1:0]  st;
    } alloc_result_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              mode;
    logic [15:0]       request_bytes;
    logic [15:0]       block_offset;
    logic              out_valid;
    logic              out_ready;
    logic [15:0]       payload_offset;
    logic [1:0]        status;
    logic              cfg_we;
    logic [SIZE_W-1:0] cfg_wdata;

    // Predicted allocator state: free extent table, block sizes and heap size.
    int unsigned       fl_start [NUM_CELLS];
    int unsigned       fl_size  [NUM_CELLS];
    int unsigned       fl_count;
    logic [SIZE_W-1:0] blk_len  [STORE_DEPTH];
    int unsigned       heap_len;

    alloc_result_t     pending_results[$];
    logic [15:0]       live_blocks[$];    // blocks currently held by the "user"
    logic [15:0]       touched_blocks[$]; // offsets whose size entry has been written, up to 4096 of them

    int unsigned tx_idle_pct;
    int unsigned rx_stall_pct;
    int unsigned rx_hold;
    int unsigned quiet_cycles;
    int unsigned errors;
    int unsigned n_alloc, n_free, n_oom, n_full, n_results;

    first_fit_heap_allocator_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .request_bytes  (request_bytes),
        .block_offset   (block_offset),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .payload_offset (payload_offset),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    always #4 clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic void rebuild_table(input logic [SIZE_W-1:0] value);
        int unsigned v;
        v = int'(value) & ~7;
        if (v < 64) v = 64;
        if (v > HEAP_MAX_BYTES) v = HEAP_MAX_BYTES;
        heap_len = v;
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            fl_start[i] = 0;
            fl_size[i]  = 0;
        end
        fl_size[0] = heap_len - HEADER_BYTES;
        fl_count   = 1;
    endfunction

    function automatic void drop_extent(input int unsigned p);
        for (int unsigned i = p; i + 1 < fl_count; i++)
        begin
            fl_start[i] = fl_start[i+1];
            fl_size[i]  = fl_size[i+1];
        end
        if (fl_count > 0) fl_count--;
    endfunction

    // Return a block to the table, merging with either neighbour; 0 when it must insert into a full table.
    function automatic bit return_extent(input int unsigned h, input int unsigned sz);
        int unsigned p;
        bit          join_l, join_r;
        p = 0;
        while (p < fl_count && fl_start[p] < h) p++;
        join_l = p > 0 && fl_start[p-1] + HEADER_BYTES + fl_size[p-1] == h;
        join_r = p < fl_count && h + HEADER_BYTES + sz == fl_start[p];
        if (join_l && join_r)
        begin
            fl_size[p-1] += 2 * HEADER_BYTES + sz + fl_size[p];
            drop_extent(p);
        end
        else if (join_l)
            fl_size[p-1] += HEADER_BYTES + sz;
        else if (join_r)
        begin
            fl_size[p]  += HEADER_BYTES + sz;
            fl_start[p]  = h;
        end
        else
        begin
            if (fl_count >= NUM_CELLS) return 0;
            for (int unsigned i = fl_count; i > p; i--)
            begin
                fl_start[i] = fl_start[i-1];
                fl_size[i]  = fl_size[i-1];
            end
            fl_start[p] = h;
            fl_size[p]  = sz;
            fl_count++;
        end
        return 1;
    endfunction

    function automatic alloc_result_t predict_item(input logic op, input logic [15:0] req,
                                                   input logic [15:0] off);
        alloc_result_t r;
        int unsigned   need, i, s, sz, pay, h, fin;
        r.offset = '0;
        r.st     = ST_DONE;
        if (op == OP_ALLOC)
        begin
            need = (int'(req) + 7) & ~7;
            for (i = 0; i < fl_count; i++)
                if (fl_size[i] >= need && fl_start[i] + HEADER_BYTES < heap_len) break;
            if (i >= fl_count)
            begin
                r.st = ST_OOM;
                return r;
            end
            s  = fl_start[i];
            sz = fl_size[i];
            drop_extent(i);
            if (sz >= need + HEADER_BYTES + 8)
            begin
                void'(return_extent(s + HEADER_BYTES + need, sz - need - HEADER_BYTES));
                sz = need;
            end
            pay = s + HEADER_BYTES;
            blk_len[pay >> 3] = SIZE_W'(sz);
            r.offset = 16'(pay);
            return r;
        end
        // free: null and malformed offsets are ignored with a clean status
        if (off == 0 || off < HEADER_BYTES || off[2:0] != 3'(HEADER_BYTES)) return r;
        sz  = blk_len[off >> 3];
        h   = off - HEADER_BYTES;
        fin = off + sz;
        if (fin > heap_len) return r;
        for (i = 0; i < fl_count; i++)
            if (h < fl_start[i] + HEADER_BYTES + fl_size[i] && fl_start[i] < fin) return r;
        if (!return_extent(h, sz)) r.st = ST_FULL;
        return r;
    endfunction

    // ---------------------------------------------------------------- channels

    // Offer one item, hold it until accepted, then predict its result.
    task automatic send_item(input logic op, input logic [15:0] req, input logic [15:0] off);
        alloc_result_t r;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= op;
        request_bytes <= req;
        block_offset  <= off;
        do @(posedge clk); while (!in_ready);
        r = predict_item(op, req, off);
        pending_results.push_back(r);
        if (op == OP_ALLOC)
        begin
            n_alloc++;
            if (r.st == ST_DONE)
            begin
                live_blocks.push_back(r.offset);
                if (touched_blocks.size() < 4096) touched_blocks.push_back(r.offset);
            end
        end
        else
            n_free++;
        if (r.st == ST_OOM)  n_oom++;
        if (r.st == ST_FULL) n_full++;
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_heap(input logic [SIZE_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        rebuild_table(value);
        live_blocks.delete();
        @(posedge clk);
    endtask

    // Receiver: random stalls, or a long hold when a test asks for one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (rx_hold > 0)
        begin
            rx_hold   = rx_hold - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Compare each result with the oldest prediction.
    always @(posedge clk)
    begin
        alloc_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result offset=%0d status=%0d",
                         $time, payload_offset, status);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (payload_offset !== exp_r.offset)
                begin
                    $display("%0t: payload_offset expected %0d actual %0d",
                             $time, exp_r.offset, payload_offset);
                    errors++;
                end
                if (status !== exp_r.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, exp_r.st, status);
                    errors++;
                end
            end
        end
    end

    // Watchdog: give up when nothing has moved for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------------------------------------------------------- tests

    // Smallest heap: split, exact fit, no split, merge, out of memory, zero request.
    task automatic test_small_heap;
        write_heap('0);               // clamps up to 64 bytes
        send_item(OP_ALLOC, 16'd8, '0);
        send_item(OP_ALLOC, 16'd1, '0);
        send_item(OP_ALLOC, 16'd0, '0);
        send_item(OP_FREE, '0, 16'd56);
        send_item(OP_FREE, '0, 16'd24);
        send_item(OP_ALLOC, 16'd33, '0);   // whole extent, too little left to split
        send_item(OP_ALLOC, 16'hFFFF, '0);
        send_item(OP_FREE, '0, 16'd24);
        send_item(OP_ALLOC, 16'd0, '0);
        send_item(OP_ALLOC, 16'd0, '0);
    endtask

    // Full heap: null, misaligned, below-header and double frees are ignored.
    task automatic test_bad_frees;
        write_heap(17'h1FFFF);        // clamps down to the maximum heap
        send_item(OP_ALLOC, 16'd100, '0);
        send_item(OP_ALLOC, 16'hFFFF, '0);
        send_item(OP_ALLOC, 16'hFFF0, '0);
        send_item(OP_FREE, '0, 16'd0);
        send_item(OP_FREE, '0, 16'd8);
        send_item(OP_FREE, '0, 16'd25);
        send_item(OP_FREE, '0, 16'hFFFF);
        send_item(OP_FREE, '0, 16'd24);
        send_item(OP_FREE, '0, 16'd24);
        send_item(OP_ALLOC, 16'd65000, '0);
        send_item(OP_FREE, 16'hFFFF, 16'd24);
    endtask

    // Fragment the heap until the table is full, then free two more isolated blocks.
    task automatic test_table_full;
        logic [15:0] blocks[$];
        write_heap(17'h10000);
        for (int i = 0; i < 130; i++)
            send_item(OP_ALLOC, 16'd8, '0);
        blocks = live_blocks;
        for (int i = 0; i <= 128; i += 2)
            send_item(OP_FREE, '0, blocks[i]);
        drain();
    endtask

    // Random item: mostly well-formed allocate/free traffic, some noise.
    task automatic random_item;
        int unsigned pick, k;
        logic [15:0] v;
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            if ($urandom_range(19) == 0) v = 16'($urandom);
            else                         v = 16'($urandom_range(0, 200));
            send_item(OP_ALLOC, v, 16'($urandom));
        end
        else if (pick < 85 && live_blocks.size() != 0)
        begin
            k = $urandom_range(live_blocks.size() - 1);
            v = live_blocks[k];
            live_blocks.delete(k);
            send_item(OP_FREE, 16'($urandom), v);
        end
        else
        begin
            case ($urandom_range(3))
                0: v = '0;
                1: v = 16'($urandom_range(1, 23));
                2: v = 16'($urandom) | 16'($urandom_range(1, 7));
                default: v = touched_blocks.size() != 0 ?
                             touched_blocks[$urandom_range(touched_blocks.size() - 1)] : '0;
            endcase
            send_item(OP_FREE, 16'($urandom), v);
        end
    endtask

    task automatic test_random(input logic [SIZE_W-1:0] heap, input int unsigned tx_pct,
                               input int unsigned rx_pct, input int unsigned count);
        write_heap(heap);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (count) random_item();
        drain();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
    endtask

    // Hold the receiver off while the sender keeps offering, so the input stalls.
    task automatic test_backpressure;
        write_heap(17'd1024);
        rx_hold = 400;
        repeat (30) random_item();
        drain();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      <= 1'b0;
        mode          <= OP_ALLOC;
        request_bytes <= '0;
        block_offset  <= '0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        rx_hold       = 0;
        errors        = 0;
        n_alloc = 0; n_free = 0; n_oom = 0; n_full = 0; n_results = 0;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            blk_len[i] = '0;
        end
        rebuild_table(SIZE_W'(HEAP_MAX_BYTES));
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        test_small_heap();
        test_bad_frees();
        test_table_full();
        test_random(17'h10000, 0, 0, 60);
        test_random(17'd1024, 75, 0, 60);
        test_random(17'd200, 0, 75, 60);
        test_random(17'd4100, 8, 8, 60);
        test_backpressure();
        drain();

        $display("Covered %0d allocates and %0d frees over heaps from 64 to 65536 bytes,",
                 n_alloc, n_free);
        $display("with %0d out-of-memory and %0d table-full results among %0d checked.",
                 n_oom, n_full, n_results);
        if (errors == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
